/* rtl/degenerate_triangle_filter_top_macros.svh */
// Assertion macros for the degenerate triangle filter.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef DEGENERATE_TRIANGLE_FILTER_TOP_MACROS_SVH
`define DEGENERATE_TRIANGLE_FILTER_TOP_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define DTF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define DTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dtf_pkg.sv */
// Shared widths, codes and state type of the degenerate triangle filter.
// No dependencies; used by the stream interfaces and the top level.
package dtf_pkg;

    localparam int VERTEX_DEPTH_DEF = 1024;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 10;
    localparam int COORD_W = 24;
    localparam int INDEX_W = 16;
    localparam int EPS_W   = 23;
    localparam int VCNT_W  = 11;
    localparam int TOTAL_W = 32;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_SEL_BIT = 2;

    localparam int CORNERS = 3;
    localparam int AXES    = 3;
    localparam int VTX_W   = AXES * COORD_W;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int ACC_W   = SQ_W + 2;
    localparam int EPSSQ_W = 2 * EPS_W;
    localparam int CNT_W   = 3;

    localparam logic [CMD_W-1:0] CMD_VERTEX   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRIANGLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAIL     = 2'd2;

    localparam logic REG_EPSILON      = 1'b0;
    localparam logic REG_VERTEX_COUNT = 1'b1;

    localparam logic [1:0] PAIR_AB = 2'd0;
    localparam logic [1:0] PAIR_BC = 2'd1;
    localparam logic [1:0] PAIR_AC = 2'd2;

    localparam logic [CNT_W-1:0] AXIS_X = 3'd0;
    localparam logic [CNT_W-1:0] AXIS_Y = 3'd1;
    localparam logic [CNT_W-1:0] AXIS_Z = 3'd2;

    // last step of the corner fetch and of the per-pair distance pipeline
    localparam logic [CNT_W-1:0] FETCH_LAST = CNT_W'(CORNERS);
    localparam logic [CNT_W-1:0] PAIR_LAST  = CNT_W'(AXES + 1);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_PAIR,
        S_CHECK,
        S_DONE
    } t_state;

endpackage

/* rtl/dtf_in_if.sv */
// Input item channel of the degenerate triangle filter: valid, ready, payload.
// Depends on dtf_pkg for the field widths.
interface dtf_in_if;
    import dtf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic [SLOT_W-1:0]         vertex_slot;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [INDEX_W-1:0]        index_a;
    logic [INDEX_W-1:0]        index_b;
    logic [INDEX_W-1:0]        index_c;

    modport source (
        output valid, command, vertex_slot, pos_x, pos_y, pos_z,
               index_a, index_b, index_c,
        input  ready
    );

    modport sink (
        input  valid, command, vertex_slot, pos_x, pos_y, pos_z,
               index_a, index_b, index_c,
        output ready
    );
endinterface

/* rtl/dtf_out_if.sv */
// Result channel of the degenerate triangle filter: valid, ready, payload.
// Depends on dtf_pkg for the field widths.
interface dtf_out_if;
    import dtf_pkg::*;

    logic               valid;
    logic               ready;
    logic               keep;
    logic [TOTAL_W-1:0] removed_total;

    modport source (
        output valid, keep, removed_total,
        input  ready
    );

    modport sink (
        input  valid, keep, removed_total,
        output ready
    );
endinterface

/* rtl/degenerate_triangle_filter_top.sv */
// Degenerate triangle filter: vertex memory, pair distance sequencer, APB registers.
// Depends on dtf_pkg, dtf_in_if, dtf_out_if and the assertion macro header.
//
// Usage:
//   i_in carries one item per transaction: a vertex write (command 0), a triangle
//   test (command 1) or a trailing incomplete triangle (command 2). Every item
//   gives one transaction on o_out: keep, and the saturating removed count after it.
//   epsilon and vertex_count sit on the APB port at byte addresses 0 and 4; write
//   them only while the block is idle.
// Timing:
//   One item is in work at a time. A vertex write, tail, unused command or
//   triangle with an index at or beyond the vertex count (or the memory depth,
//   where that is smaller) goes from acceptance straight to the done state. A
//   triangle that is tested reads its three corners through the single read
//   port of the vertex memory, then checks the pairs in turn on one shared
//   squaring multiplier, and stops at the first close pair.
//   The next item can be taken in the cycle after a result is loaded.
// Reset and stall:
//   Reset clears the control, configuration and removed-count registers; vertex
//   memory, datapath and output data registers are undefined until written. A
//   result waits in the output register while o_out.ready is low; the next item
//   is still taken and held in its final step until the output register frees.
`include "degenerate_triangle_filter_top_macros.svh"

module degenerate_triangle_filter_top #(
    parameter int VERTEX_DEPTH = dtf_pkg::VERTEX_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dtf_in_if.sink                      i_in,
    dtf_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dtf_pkg::PADDR_W-1:0] paddr,
    input  logic [dtf_pkg::PDATA_W-1:0] pwdata,
    output logic [dtf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import dtf_pkg::*;

    localparam int AW      = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int DEPTH_W = $clog2(VERTEX_DEPTH + 1);
    localparam int CMP_A   = (DEPTH_W > INDEX_W) ? DEPTH_W : INDEX_W;
    localparam int CMP_B   = (VCNT_W > SLOT_W) ? VCNT_W : SLOT_W;
    localparam int CMP_W   = (CMP_A > CMP_B) ? CMP_A : CMP_B;

    // configuration
    logic [EPS_W-1:0]  r_eps;
    logic [VCNT_W-1:0] r_vcnt;
    logic              cfg_wr;

    // control
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]        r_pair, n_pair;
    logic              r_keep, n_keep;
    logic              r_removal, n_removal;
    logic [TOTAL_W-1:0] r_removed, n_removed;
    logic              r_out_valid, n_out_valid;
    logic              r_out_keep;
    logic [TOTAL_W-1:0] r_out_total;

    // datapath
    logic [VTX_W-1:0]   r_mem [VERTEX_DEPTH];
    logic [VTX_W-1:0]   r_rd_data;
    logic [AW-1:0]      r_idx_a, r_idx_b, r_idx_c;
    logic [VTX_W-1:0]   r_vtx_a, r_vtx_b, r_vtx_c;
    logic [COORD_W-1:0] r_absd;
    logic [SQ_W-1:0]    r_sq;
    logic [ACC_W-1:0]   r_acc;
    logic [EPSSQ_W-1:0] r_eps_sq;

    logic               in_fire;
    logic               out_load;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               slot_ok;
    logic [CMP_W-1:0]   limit;
    logic               idx_bad;
    logic [VTX_W-1:0]   vp, vq;
    logic [COORD_W-1:0] cp, cq;
    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0] absd;
    logic               close_pair;

    // ---------------- APB registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps  <= '0;
            r_vcnt <= '0;
        end else if (cfg_wr) begin
            case (paddr[REG_SEL_BIT])
                REG_EPSILON:      r_eps  <= pwdata[EPS_W-1:0];
                REG_VERTEX_COUNT: r_vcnt <= pwdata[VCNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_EPSILON:      prdata = PDATA_W'(r_eps);
            REG_VERTEX_COUNT: prdata = PDATA_W'(r_vcnt);
            default:          prdata = '0;
        endcase
    end

    // ---------------- decode ----------------
    always_comb begin
        limit = (CMP_W'(r_vcnt) > CMP_W'(VERTEX_DEPTH)) ? CMP_W'(VERTEX_DEPTH)
                                                        : CMP_W'(r_vcnt);
        idx_bad = (CMP_W'(i_in.index_a) >= limit) || (CMP_W'(i_in.index_b) >= limit)
               || (CMP_W'(i_in.index_c) >= limit);
        slot_ok = CMP_W'(i_in.vertex_slot) < CMP_W'(VERTEX_DEPTH);
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.command == CMD_TRIANGLE && !idx_bad) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FETCH: begin
                if (r_cnt == FETCH_LAST) n_state = S_PAIR;
            end
            S_PAIR: begin
                if (r_cnt == PAIR_LAST) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (close_pair || r_pair == PAIR_AC) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_PAIR;
                end
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- outputs and controls ----------------
    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        in_fire    = i_in.valid && i_in.ready;
        out_load   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
        mem_we     = in_fire && (i_in.command == CMD_VERTEX) && slot_ok;
        wr_addr    = AW'(i_in.vertex_slot);
        case (r_cnt)
            3'd0:    rd_addr = r_idx_a;
            3'd1:    rd_addr = r_idx_b;
            default: rd_addr = r_idx_c;
        endcase
        o_out.valid         = r_out_valid;
        o_out.keep          = r_out_keep;
        o_out.removed_total = r_out_total;
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_pair      = r_pair;
        n_keep      = r_keep;
        n_removal   = r_removal;
        n_removed   = r_removed;
        n_out_valid = r_out_valid;
        case (r_state)
            S_IDLE: begin
                n_cnt  = '0;
                n_pair = PAIR_AB;
                if (in_fire) begin
                    n_keep    = 1'b0;
                    n_removal = (i_in.command == CMD_TAIL)
                             || (i_in.command == CMD_TRIANGLE && idx_bad);
                end
            end
            S_FETCH: begin
                n_cnt = (r_cnt == FETCH_LAST) ? '0 : r_cnt + 1'b1;
            end
            S_PAIR: begin
                n_cnt = r_cnt + 1'b1;
            end
            S_CHECK: begin
                n_cnt = '0;
                if (close_pair) begin
                    n_removal = 1'b1;
                end else if (r_pair == PAIR_AC) begin
                    n_keep = 1'b1;
                end else begin
                    n_pair = r_pair + 1'b1;
                end
            end
            default: ;
        endcase
        if (out_load && r_removal && r_removed != TOTAL_MAX) begin
            n_removed = r_removed + 1'b1;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pair      <= PAIR_AB;
            r_keep      <= 1'b0;
            r_removal   <= 1'b0;
            r_removed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pair      <= n_pair;
            r_keep      <= n_keep;
            r_removal   <= n_removal;
            r_removed   <= n_removed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_keep  <= r_keep;
            r_out_total <= n_removed;
        end
    end

    // ---------------- vertex memory ----------------
    // Writes land at acceptance and reads start the cycle after, so a triangle
    // always sees the vertex written just before it.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= {i_in.pos_x, i_in.pos_y, i_in.pos_z};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // capture corner indices, the squared epsilon and the fetched corners
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_idx_a <= AW'(i_in.index_a);
            r_idx_b <= AW'(i_in.index_b);
            r_idx_c <= AW'(i_in.index_c);
        end
        if (r_state == S_FETCH) begin
            case (r_cnt)
                3'd0:    r_eps_sq <= r_eps * r_eps;
                3'd1:    r_vtx_a  <= r_rd_data;
                3'd2:    r_vtx_b  <= r_rd_data;
                default: r_vtx_c  <= r_rd_data;
            endcase
        end
    end

    // ---------------- pair distance ----------------
    always_comb begin
        case (r_pair)
            PAIR_AB: begin vp = r_vtx_a; vq = r_vtx_b; end
            PAIR_BC: begin vp = r_vtx_b; vq = r_vtx_c; end
            default: begin vp = r_vtx_a; vq = r_vtx_c; end
        endcase
        case (r_cnt)
            AXIS_X:  begin cp = vp[3*COORD_W-1:2*COORD_W]; cq = vq[3*COORD_W-1:2*COORD_W]; end
            AXIS_Y:  begin cp = vp[2*COORD_W-1:COORD_W];   cq = vq[2*COORD_W-1:COORD_W];   end
            default: begin cp = vp[COORD_W-1:0];           cq = vq[COORD_W-1:0];           end
        endcase
        diff = $signed({cp[COORD_W-1], cp}) - $signed({cq[COORD_W-1], cq});
        absd = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);
        close_pair = r_acc <= ACC_W'(r_eps_sq);
    end

    // difference, square, accumulate: three axes overlap over five steps
    always_ff @(posedge i_clk) begin
        if (r_state == S_PAIR) begin
            r_absd <= absd;
            r_sq   <= r_absd * r_absd;
            if (r_cnt == AXIS_Z) begin
                r_acc <= ACC_W'(r_sq);
            end else if (r_cnt > AXIS_Z) begin
                r_acc <= r_acc + ACC_W'(r_sq);
            end
        end
    end

    // ---------------- assertions ----------------
    `DTF_ASSERT_NOW(a_fetch_in_range, (r_state == S_FETCH) && (r_cnt < FETCH_LAST), CMP_W'(rd_addr) < limit, "corner fetch beyond vertex count")
    `DTF_ASSERT_NEXT(a_count_monotonic, 1'b1, r_removed >= $past(r_removed), "removed count went down")
    `DTF_ASSERT_NEXT(a_keep_no_count, out_load && r_keep, r_removed == $past(r_removed), "kept triangle changed the removed count")
    `DTF_ASSERT_NOW(a_keep_excludes_removal, r_state == S_DONE, !(r_keep && r_removal), "result both kept and removed")

endmodule
